>>> src/dbs_pkg.sv
// shared types and constants for the depth background subtractor
package dbs_pkg;

  localparam int IDX_W     = 14;
  localparam int IDX_EXT_W = 17;
  localparam int DIST_W    = 16;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 22;
  localparam int SQ_W      = 38;
  localparam int K_W       = 4;
  localparam int KK_W      = 2 * K_W;

  localparam int ND_W  = CNT_W + DIST_W;
  localparam int SS_W  = 2 * SUM_W;
  localparam int NQ_W  = CNT_W + SQ_W;
  localparam int LHS_W = 2 * ND_W;
  localparam int RHS_W = KK_W + NQ_W;

  localparam logic [K_W-1:0]  K_RESET  = 4'd5;
  localparam logic [KK_W-1:0] KK_RESET = KK_W'(K_RESET) * KK_W'(K_RESET);

  localparam logic [1:0] CMD_LEARN    = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  typedef enum logic [1:0] {
    OP_LEARN,
    OP_CLASSIFY,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_READ,
    B_MUL1,
    B_MUL2,
    B_CMP
  } back_state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  pixel_index;
    logic [DIST_W-1:0] distance_mm;
    logic              distance_valid;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_pixel_index;
    logic [DIST_W-1:0] out_distance_mm;
    logic              keep;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  pixel_index;
    logic [DIST_W-1:0] distance_mm;
    logic              distance_valid;
    logic              in_frame;
  } op_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq_sum;
  } stat_t;

endpackage

>>> src/dbs_fifo.sv
// small synchronous fifo used for the command and result queues
module dbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/dbs_front.sv
// front end: accepts input items, decodes commands and drops no-op items
module dbs_front #(
  parameter int PIXELS = 16384
) (
  input  logic               push,
  input  dbs_pkg::in_item_t  in_data,
  output logic               full,
  input  logic               init_done,
  input  logic               q_full,
  output logic               q_wr,
  output dbs_pkg::op_item_t  q_item
);
  import dbs_pkg::*;

  logic [IDX_EXT_W-1:0] idx_ext;
  logic                 in_frame;
  logic                 needed;
  op_t                  op;

  assign idx_ext  = IDX_EXT_W'(in_data.pixel_index);
  assign in_frame = (idx_ext < IDX_EXT_W'(PIXELS));

  always_comb begin
    needed = 1'b0;
    op     = OP_CLASSIFY;
    case (in_data.cmd)
      CMD_LEARN: begin
        needed = in_frame & in_data.distance_valid;
        op     = OP_LEARN;
      end
      CMD_CLASSIFY: begin
        needed = 1'b1;
        op     = OP_CLASSIFY;
      end
      CMD_CLEAR: begin
        needed = in_frame;
        op     = OP_CLEAR;
      end
      default: begin
        needed = 1'b0;
        op     = OP_CLASSIFY;
      end
    endcase
  end

  // nothing enters until the statistics memory has been swept
  assign full = ~init_done | q_full;
  assign q_wr = push & ~full & needed;

  assign q_item.op             = op;
  assign q_item.pixel_index    = in_data.pixel_index;
  assign q_item.distance_mm    = in_data.distance_mm;
  assign q_item.distance_valid = in_data.distance_valid;
  assign q_item.in_frame       = in_frame;

endmodule

>>> src/dbs_back.sv
// back end: statistics memory, read-modify-write sequencer and background test
module dbs_back #(
  parameter int PIXELS     = 16384,
  parameter int MAX_FRAMES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dbs_pkg::KK_W-1:0]   kk,
  input  logic                       q_empty,
  input  dbs_pkg::op_item_t          q_item,
  output logic                       q_pop,
  input  logic                       out_full,
  output logic                       out_push,
  output dbs_pkg::out_item_t         out_item,
  output logic                       init_done
);
  import dbs_pkg::*;

  localparam int ADDR_W = $clog2(PIXELS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_FRAMES);

  stat_t stat_mem [PIXELS];

  back_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] init_addr_r, init_addr_nxt;

  op_item_t cur_r;
  stat_t    rd_r;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  stat_t             mem_wdata;

  logic [IDX_EXT_W-1:0] q_idx_ext, cur_idx_ext;
  logic [ADDR_W-1:0]    q_addr, cur_addr;

  stat_t               stat_in, learned;
  logic [2*DIST_W-1:0] d_sq;

  logic [ND_W-1:0]  nd_r, diff_r;
  logic [SUM_W-1:0] s_r;
  logic [SS_W-1:0]  ss_r;
  logic [NQ_W-1:0]  nq_r, spread_r;
  logic [LHS_W-1:0] lhs_r;
  logic [RHS_W-1:0] rhs_r;
  logic [ND_W-1:0]  s_ext;
  logic [NQ_W-1:0]  ss_ext;

  assign q_idx_ext   = IDX_EXT_W'(q_item.pixel_index);
  assign q_addr      = q_idx_ext[ADDR_W-1:0];
  assign cur_idx_ext = IDX_EXT_W'(cur_r.pixel_index);
  assign cur_addr    = cur_idx_ext[ADDR_W-1:0];
  assign init_done   = (state_r != B_INIT);

  // pixels beyond the frame read as an empty model
  assign stat_in = cur_r.in_frame ? rd_r : '0;

  assign d_sq           = cur_r.distance_mm * cur_r.distance_mm;
  assign learned.count  = rd_r.count + CNT_W'(1);
  assign learned.sum    = rd_r.sum + SUM_W'(cur_r.distance_mm);
  assign learned.sq_sum = rd_r.sq_sum + SQ_W'(d_sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      init_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    q_pop         = 1'b0;
    out_push      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = init_addr_r;
    mem_wdata     = '0;
    case (state_r)
      B_INIT: begin
        mem_we = 1'b1;
        if (init_addr_r == LAST_ADDR) begin
          state_nxt = B_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + ADDR_W'(1);
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          case (q_item.op)
            OP_CLEAR: begin
              q_pop     = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = q_addr;
            end
            OP_LEARN: begin
              q_pop     = 1'b1;
              mem_re    = 1'b1;
              state_nxt = B_READ;
            end
            OP_CLASSIFY: begin
              // a result slot is held for the whole classify pass
              if (!out_full) begin
                q_pop     = 1'b1;
                mem_re    = 1'b1;
                state_nxt = B_READ;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        if (cur_r.op == OP_LEARN) begin
          if (rd_r.count < CNT_MAX) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = learned;
          end
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_MUL1;
        end
      end
      B_MUL1: begin
        state_nxt = B_MUL2;
      end
      B_MUL2: begin
        state_nxt = B_CMP;
      end
      B_CMP: begin
        out_push  = 1'b1;
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stat_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= stat_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
  end

  assign s_ext  = ND_W'(s_r);
  assign ss_ext = NQ_W'(ss_r);

  // test (n*d - S)^2 < k^2 * (n*Q - S^2): products, then differences, then the final products, each registered
  always_ff @(posedge clk) begin
    nd_r     <= ND_W'(stat_in.count) * ND_W'(cur_r.distance_mm);
    s_r      <= stat_in.sum;
    ss_r     <= SS_W'(stat_in.sum) * SS_W'(stat_in.sum);
    nq_r     <= NQ_W'(stat_in.count) * NQ_W'(stat_in.sq_sum);
    diff_r   <= (nd_r >= s_ext) ? (nd_r - s_ext) : (s_ext - nd_r);
    spread_r <= (nq_r >= ss_ext) ? (nq_r - ss_ext) : '0;
    lhs_r    <= LHS_W'(diff_r) * LHS_W'(diff_r);
    rhs_r    <= RHS_W'(kk) * RHS_W'(spread_r);
  end

  assign out_item.out_pixel_index = cur_r.pixel_index;
  assign out_item.out_distance_mm = cur_r.distance_mm;
  assign out_item.keep = cur_r.distance_valid & ~(RHS_W'(lhs_r) < rhs_r);

endmodule

>>> src/depth_background_subtractor.sv
// top level: depth background subtractor with per-pixel gaussian statistics
// result path: a classify transfer goes through the command queue, the read and the
//   MUL1, MUL2 and CMP states and the result queue; learn and clear have no result
// sequencing: one pass of the statistics memory sequencer per item: clear writes from idle,
//   learn reads then writes, classify reads then runs three arithmetic stages
// reset: k returns to 5 and a clearing pass zeroes all PIXELS entries, during which
//   full stays high; configuration writes are taken as ever
module depth_background_subtractor #(
  parameter int PIXELS     = 16384,
  parameter int MAX_FRAMES = 64,
  parameter int CMD_DEPTH  = 4,
  parameter int OUT_DEPTH  = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      push,
  input  dbs_pkg::in_item_t         in_data,
  output logic                      full,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output dbs_pkg::out_item_t        out_data,
  // configuration: stdev multiple k
  input  logic                      cfg_wr_en,
  input  logic [dbs_pkg::K_W-1:0]   cfg_wr_data
);
  import dbs_pkg::*;

  // k squared is kept instead of k, that is all the test needs
  logic [KK_W-1:0] kk_r;

  logic      init_done;
  logic      q_wr, q_full, q_empty, q_pop;
  op_item_t  q_wr_item, q_rd_item;
  logic      out_push, out_full;
  out_item_t out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kk_r <= KK_RESET;
    end else if (cfg_wr_en) begin
      kk_r <= KK_W'(cfg_wr_data) * KK_W'(cfg_wr_data);
    end
  end

  // front end decodes and filters the input transfer
  dbs_front #(
    .PIXELS (PIXELS)
  ) u_front (
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .init_done (init_done),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (q_wr_item)
  );

  // command queue decouples the front end from the memory sequencer
  dbs_fifo #(
    .WIDTH ($bits(op_item_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  // back end owns the statistics and does the background test
  dbs_back #(
    .PIXELS     (PIXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kk        (kk_r),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item),
    .init_done (init_done)
  );

  // result queue lets the sequencer run on while a result waits for pop
  dbs_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_item),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

`ifndef SYNTHESIS
  a_result_slot_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full result queue");

  a_no_result_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> empty)
    else $error("result present before the clearing pass finished");

  a_pop_only_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("sequencer took a command from an empty queue");
`endif

endmodule

>>> verif/tb_top.sv
// testbench for the depth background subtractor: random and directed pixel traffic checked
// against a per-pixel statistics predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dbs_pkg::*;

  localparam int PIXEL_COUNT  = 16384;
  localparam int FRAME_LIMIT  = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_SIZE    = 6;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // per-pixel background statistics and the keep decisions they imply
  class background_predictor;
    bit [CNT_W-1:0] frames [PIXEL_COUNT];
    bit [SUM_W-1:0] depth_sum [PIXEL_COUNT];
    bit [SQ_W-1:0]  depth_sq_sum [PIXEL_COUNT];
    bit [K_W-1:0]   multiple;
    out_item_t      expected_keeps [$];
    int             failures;

    function new();
      multiple = K_RESET;
      failures = 0;
    endfunction

    // squared deviation against k^2 times n^2 variance, all exact integers
    function bit near_mean(longint unsigned d, longint unsigned n, longint unsigned s,
                           longint unsigned q);
      longint unsigned nd, dev, lhs, nq, ss, spread, kk;
      nd     = n * d;
      dev    = (nd >= s) ? nd - s : s - nd;
      lhs    = dev * dev;
      nq     = n * q;
      ss     = s * s;
      spread = (nq >= ss) ? nq - ss : 64'd0;
      kk     = 64'(multiple);
      return lhs < kk * kk * spread;
    endfunction

    function void note_item(in_item_t item);
      int unsigned     px;
      longint unsigned d;
      out_item_t       res;
      px = 32'(item.pixel_index);
      d  = 64'(item.distance_mm);
      case (item.cmd)
        CMD_LEARN: begin
          if (item.distance_valid && frames[px] < FRAME_LIMIT) begin
            frames[px]       = frames[px] + 1'b1;
            depth_sum[px]    = SUM_W'(depth_sum[px] + d);
            depth_sq_sum[px] = SQ_W'(depth_sq_sum[px] + d * d);
          end
        end
        CMD_CLEAR: begin
          frames[px]       = '0;
          depth_sum[px]    = '0;
          depth_sq_sum[px] = '0;
        end
        CMD_CLASSIFY: begin
          res.out_pixel_index = item.pixel_index;
          res.out_distance_mm = item.distance_mm;
          if (!item.distance_valid) begin
            res.keep = 1'b0;
          end else if (frames[px] == 0) begin
            res.keep = 1'b1;
          end else begin
            res.keep = !near_mean(d, frames[px], depth_sum[px], depth_sq_sum[px]);
          end
          expected_keeps.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_keeps.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: pixel %0d distance %0d keep %0b",
                   got.out_pixel_index, got.out_distance_mm, got.keep);
        return;
      end
      want = expected_keeps.pop_front();
      if (got.out_pixel_index !== want.out_pixel_index ||
          got.out_distance_mm !== want.out_distance_mm ||
          got.keep !== want.keep) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected pixel %0d distance %0d keep %0b, got %0d %0d %0b",
                   want.out_pixel_index, want.out_distance_mm, want.keep,
                   got.out_pixel_index, got.out_distance_mm, got.keep);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n       = 1'b0;
  logic            push        = 1'b0;
  in_item_t        in_data     = '0;
  logic            full;
  logic            empty;
  logic            pop         = 1'b0;
  out_item_t       out_data;
  logic            cfg_wr_en   = 1'b0;
  logic [K_W-1:0]  cfg_wr_data = '0;

  background_predictor model = new();

  // knobs shared between the sender and the receiver
  bit tx_gaps       = 1'b1;
  bit rx_stalls     = 1'b1;
  bit long_hold_req = 1'b0;
  int items_sent    = 0;

  logic [IDX_W-1:0] pool [POOL_SIZE];

  depth_background_subtractor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_data     (in_data),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [IDX_W-1:0] px,
                                         logic [DIST_W-1:0] d, logic v);
    in_item_t item;
    item.cmd            = cmd;
    item.pixel_index    = px;
    item.distance_mm    = d;
    item.distance_valid = v;
    return item;
  endfunction

  // keep a signed distance guess inside the 16-bit range
  function automatic logic [DIST_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[DIST_W-1:0];
  endfunction

  // offer one item and wait for its transfer; push stays high unless a gap follows
  task automatic offer(input in_item_t item);
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    model.note_item(item);
    items_sent++;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop sending, let every expected result come out, then give learn/clear work time to retire
  task automatic settle();
    push <= 1'b0;
    while (model.expected_keeps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the block is idle here, so the new multiple applies from the next item on
  task automatic write_multiple(input logic [K_W-1:0] k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model.multiple = k;
  endtask

  // one scene on a pixel: optional clear, a run of learned samples around a center,
  // then a few probes near and far; some sequences are plain noise or broken
  task automatic run_sequence();
    int kind, runs, center, spread, v, off;
    logic [IDX_W-1:0] px;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      offer(make_item(2'($urandom_range(0, 3)), IDX_W'($urandom), DIST_W'($urandom),
                      1'($urandom)));
      return;
    end
    px = pool[$urandom_range(0, POOL_SIZE - 1)];
    if (kind == 1) begin
      // invalid learn samples only, then a probe of any validity
      repeat ($urandom_range(1, 3)) offer(make_item(CMD_LEARN, px, DIST_W'($urandom), 1'b0));
      offer(make_item(CMD_CLASSIFY, px, DIST_W'($urandom), 1'($urandom)));
      return;
    end
    if ($urandom_range(0, 2) == 0)
      offer(make_item(CMD_CLEAR, px, DIST_W'($urandom), 1'($urandom)));
    // a rare long run pushes the frame count into saturation
    runs = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 4;
      2:       spread = 100;
      default: spread = 3000;
    endcase
    center = $urandom_range(0, 65535);
    repeat (runs) begin
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      offer(make_item(CMD_LEARN, px, clip(v), $urandom_range(0, 9) != 0));
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: v = center + int'($urandom_range(0, spread)) - spread / 2;
        1: v = $urandom_range(0, 65535);
        2: begin
          off = (spread + 1) * int'($urandom_range(2, 20));
          v   = $urandom_range(0, 1) ? center + off : center - off;
        end
        default: v = center;
      endcase
      offer(make_item(CMD_CLASSIFY, px, clip(v), $urandom_range(0, 7) != 0));
    end
  endtask

  task automatic run_phase(input logic [K_W-1:0] k, input bit tx, input bit rx,
                           input int count, input bit pressure);
    int target;
    settle();
    write_multiple(k);
    tx_gaps   = tx;
    rx_stalls = rx;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = IDX_W'($urandom);
    if (pressure) begin
      // receiver goes quiet while a burst of classify transfers fills the block
      long_hold_req = 1'b1;
      repeat (30) offer(make_item(CMD_CLASSIFY, pool[$urandom_range(0, POOL_SIZE - 1)],
                                  DIST_W'($urandom), 1'b1));
    end
    target = items_sent + count;
    while (items_sent < target) run_sequence();
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // written while the clearing pass still holds full high
    write_multiple(4'd5);

    // directed: no background, invalid samples, zero variance, near and far probes,
    // the unused command, clear, and the extremes of index and distance
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd0, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'h3FFF, 16'hFFFF, 1'b0));
    offer(make_item(CMD_LEARN, 14'h3FFF, 16'hFFFF, 1'b0));
    repeat (3) offer(make_item(CMD_LEARN, 14'd0, 16'd1000, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd1000, 1'b1));
    offer(make_item(CMD_LEARN, 14'd0, 16'd1010, 1'b1));
    offer(make_item(CMD_LEARN, 14'd0, 16'd990, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd1001, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd5000, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd1000, 1'b0));
    offer(make_item(CMD_UNUSED, 14'h3FFF, 16'hFFFF, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'h3FFF, 16'hFFFF, 1'b1));
    offer(make_item(CMD_CLEAR, 14'd0, 16'hFFFF, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'd0, 16'd1000, 1'b1));
    offer(make_item(CMD_LEARN, 14'h3FFF, 16'hFFFF, 1'b1));
    offer(make_item(CMD_LEARN, 14'h3FFF, 16'd0, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'h3FFF, 16'd32768, 1'b1));
    offer(make_item(CMD_CLASSIFY, 14'h3FFF, 16'd0, 1'b1));
    offer(make_item(CMD_CLEAR, 14'h3FFF, 16'd0, 1'b0));

    // random phases, each behind a full drain: k at both ends and in between,
    // with gaps and stalls switched per phase and none at all in the last one
    run_phase(4'd15, 1'b1, 1'b1, 130, 1'b0);
    run_phase(4'd0, 1'b1, 1'b0, 110, 1'b0);
    run_phase(4'd1, 1'b0, 1'b1, 110, 1'b1);
    run_phase(K_W'($urandom_range(2, 14)), 1'b1, 1'b1, 130, 1'b0);
    run_phase(4'd3, 1'b1, 1'b1, 110, 1'b0);
    run_phase(4'd6, 1'b0, 1'b0, 110, 1'b0);

    settle();
    if (model.failures == 0 && model.expected_keeps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: check each transfer, then choose pop for the next edge
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) model.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = HOLD_CYCLES;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      pop <= (stall_left == 0);
    end
  end

  // run limit: the clearing pass plus a slow run, taken many times over
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
